// ===== hdl/swt_pkg.sv =====
// Shared types and constants of the stream window table.
package swt_pkg;

    localparam int STREAMS   = 16;
    localparam int IDX_W     = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int WIN_W     = 32;
    localparam int KEY_W     = 64;
    localparam int CHUNK_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CHUNK_W-1:0] CHUNK_CAP = CHUNK_W'(1400);

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CONGEST_BYTES  = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        REQ_ADAPT = 2'd0,
        REQ_SET   = 2'd1,
        REQ_QUERY = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic {
        BK_LOOK = 1'b0,
        BK_EXEC = 1'b1
    } t_bk_state;

    // Classified request handed from front to back.
    typedef struct packed {
        t_req               req;
        logic [KEY_W-1:0]   key;
        logic [WIN_W-1:0]   wval;
        logic [WIN_W-1:0]   dsize;
        logic               congested;
        logic               set_over;
    } t_work;

    typedef struct packed {
        t_status            status;
        logic [WIN_W-1:0]   window;
        logic               send;
        logic [CHUNK_W-1:0] chunk;
    } t_result;

endpackage

// ===== hdl/swt_front.sv =====
// Front end: accepts request items, classifies them, queues them for the back end.
module swt_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 i_req_type,
    input  logic [swt_pkg::KEY_W-1:0]  i_stream_key,
    input  logic [swt_pkg::WIN_W-1:0]  i_window_value,
    input  logic [swt_pkg::WIN_W-1:0]  i_send_bytes,
    input  logic                       i_buffer_tracked,
    input  logic [swt_pkg::WIN_W-1:0]  i_buffer_used,
    input  logic [swt_pkg::WIN_W-1:0]  i_max_window,
    input  logic [swt_pkg::WIN_W-1:0]  i_congest_bytes,
    output logic                       o_head_valid,
    output swt_pkg::t_work             o_head,
    input  logic                       i_head_pop
);
    import swt_pkg::*;

    t_work       r_q [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;
    t_work       w_item;
    logic        w_push_ok;
    logic        w_pop_ok;

    always_comb begin
        w_item = '0;
        case (t_req'(i_req_type))
            REQ_ADAPT: w_item.req = REQ_ADAPT;
            REQ_SET:   w_item.req = REQ_SET;
            default:   w_item.req = REQ_QUERY; // unused code acts as a query
        endcase
        w_item.key       = i_stream_key;
        w_item.wval      = i_window_value;
        w_item.dsize     = i_send_bytes;
        w_item.congested = i_buffer_tracked && (i_buffer_used > i_congest_bytes);
        w_item.set_over  = i_window_value > i_max_window;
    end

    assign full         = (r_count == 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_q[r_rd_ptr];
    assign w_push_ok    = push && !full;
    assign w_pop_ok     = i_head_pop && o_head_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ w_push_ok;
        n_rd_ptr = r_rd_ptr ^ w_pop_ok;
        n_count  = r_count + {1'b0, w_push_ok} - {1'b0, w_pop_ok};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_q[r_wr_ptr] <= w_item;
        end
    end

endmodule

// ===== hdl/swt_back.sv =====
// Back end: table lookup, window update and result queue.
module swt_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  swt_pkg::t_work                i_head,
    output logic                          o_head_pop,
    input  logic [swt_pkg::WIN_W-1:0]     i_initial_window,
    input  logic [swt_pkg::WIN_W-1:0]     i_max_window,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    o_status,
    output logic [swt_pkg::WIN_W-1:0]     o_window_now,
    output logic                          o_send_allowed,
    output logic [swt_pkg::CHUNK_W-1:0]   o_chunk_size
);
    import swt_pkg::*;

    // table
    logic [KEY_W-1:0] entry_key    [STREAMS];
    logic [WIN_W-1:0] entry_window [STREAMS];
    logic [STREAMS-1:0] r_valid;

    t_bk_state    r_state, n_state;
    t_work        r_work;
    logic         r_hit;
    logic         r_any_free;
    logic [IDX_W-1:0] r_idx;
    logic [WIN_W-1:0] r_cur;

    logic             w_hit;
    logic [IDX_W-1:0] w_hit_idx;
    logic             w_any_free;
    logic [IDX_W-1:0] w_free_idx;

    // result queue
    t_result      r_rq [2];
    logic         r_rq_wr, r_rq_rd;
    logic [1:0]   r_rq_count;
    logic         w_rq_full;
    logic         w_rq_pop;

    logic         w_look_fire;
    logic         w_exec_fire;
    logic         w_write;
    logic         w_alloc;
    logic [WIN_W-1:0] w_new_win;
    logic [WIN_W-1:0] w_base;
    logic [WIN_W-1:0] w_half;
    logic [WIN_W-1:0] w_floor;
    logic [WIN_W:0]   w_dbl;
    t_result          w_res;

    // parallel key match and lowest free slot
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_any_free = 1'b0;
        w_free_idx = '0;
        for (int i = 0; i < STREAMS; i++) begin
            if (r_valid[i] && (entry_key[i] == i_head.key)) begin
                w_hit     = 1'b1;
                w_hit_idx = IDX_W'(i);
            end
        end
        for (int i = STREAMS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_any_free = 1'b1;
                w_free_idx = IDX_W'(i);
            end
        end
    end

    assign w_rq_full   = (r_rq_count == 2'd2);
    assign w_rq_pop    = pop && !empty;
    assign w_look_fire = (r_state == BK_LOOK) && i_head_valid;
    assign w_exec_fire = (r_state == BK_EXEC) && !w_rq_full;

    always_comb begin
        n_state    = r_state;
        o_head_pop = 1'b0;
        case (r_state)
            BK_LOOK: begin
                if (i_head_valid) begin
                    o_head_pop = 1'b1;
                    n_state    = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (!w_rq_full) begin
                    n_state = BK_LOOK;
                end
            end
            default: n_state = BK_LOOK;
        endcase
    end

    // read-modify-write of the selected entry
    always_comb begin
        w_base  = r_hit ? r_cur : i_initial_window;
        w_half  = {1'b0, w_base[WIN_W-1:1]};
        w_floor = {2'b0, i_initial_window[WIN_W-1:2]};
        w_dbl   = {w_base, 1'b0};
        w_write   = 1'b0;
        w_alloc   = 1'b0;
        w_new_win = w_base;
        w_res     = '0;
        w_res.status = ST_OK;
        case (r_work.req)
            REQ_ADAPT: begin
                if (!r_hit && !r_any_free) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_write = 1'b1;
                    w_alloc = !r_hit;
                    if (r_work.congested) begin
                        w_new_win = (w_half > w_floor) ? w_half : w_floor;
                    end else begin
                        w_new_win = (w_dbl < {1'b0, i_max_window}) ?
                                    w_dbl[WIN_W-1:0] : i_max_window;
                    end
                end
            end
            REQ_SET: begin
                if (r_work.set_over) begin
                    w_res.status = ST_REJECT;
                end else if (!r_hit && !r_any_free) begin
                    w_res.status = ST_FULL;
                end else begin
                    w_write   = 1'b1;
                    w_alloc   = !r_hit;
                    w_new_win = r_work.wval;
                end
            end
            default: ;
        endcase
        w_res.window = w_new_win;
        w_res.send   = (r_work.dsize <= w_new_win);
        w_res.chunk  = (w_new_win[WIN_W-1:2] > (WIN_W-2)'(CHUNK_CAP)) ?
                       CHUNK_CAP : w_new_win[CHUNK_W+1:2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BK_LOOK;
            r_valid    <= '0;
            r_rq_wr    <= 1'b0;
            r_rq_rd    <= 1'b0;
            r_rq_count <= 2'd0;
        end else begin
            r_state <= n_state;
            if (w_exec_fire && w_alloc) begin
                r_valid[r_idx] <= 1'b1;
            end
            r_rq_wr    <= r_rq_wr ^ w_exec_fire;
            r_rq_rd    <= r_rq_rd ^ w_rq_pop;
            r_rq_count <= r_rq_count + {1'b0, w_exec_fire} - {1'b0, w_rq_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_look_fire) begin
            r_work     <= i_head;
            r_hit      <= w_hit;
            r_any_free <= w_any_free;
            r_idx      <= w_hit ? w_hit_idx : w_free_idx;
            r_cur      <= entry_window[w_hit_idx];
        end
        if (w_exec_fire && w_write) begin
            entry_window[r_idx] <= w_new_win;
        end
        if (w_exec_fire && w_alloc) begin
            entry_key[r_idx] <= r_work.key;
        end
        if (w_exec_fire) begin
            r_rq[r_rq_wr] <= w_res;
        end
    end

    assign empty          = (r_rq_count == 2'd0);
    assign o_status       = r_rq[r_rq_rd].status;
    assign o_window_now   = r_rq[r_rq_rd].window;
    assign o_send_allowed = r_rq[r_rq_rd].send;
    assign o_chunk_size   = r_rq[r_rq_rd].chunk;

endmodule

// ===== hdl/stream_window_table_core.sv =====
// Top level of the per-stream flow window table.
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+-----------------------------------------
//  request   | in        | push / full         | req_type, stream_key, window_value,
//            |           |                     | send_bytes, buffer_tracked, buffer_used
//  result    | out       | empty / pop         | status, window_now, send_allowed, chunk_size
//  config    | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// The back end takes each item through BK_LOOK, the key match over all
// entries, then BK_EXEC, the read-modify-write of the chosen entry, which
// waits while the result queue is full; no new item is taken until BK_EXEC is done.
// A result on the result ports can be popped at the next edge.
// Reset is synchronous; all table entries are marked free in the same cycle.
// A 2-deep request queue and a 2-deep result queue let either side stall
// without holding up the other.
module stream_window_table_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request item
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    i_req_type,
    input  logic [swt_pkg::KEY_W-1:0]     i_stream_key,
    input  logic [swt_pkg::WIN_W-1:0]     i_window_value,
    input  logic [swt_pkg::WIN_W-1:0]     i_send_bytes,
    input  logic                          i_buffer_tracked,
    input  logic [swt_pkg::WIN_W-1:0]     i_buffer_used,
    // result item
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    o_status,
    output logic [swt_pkg::WIN_W-1:0]     o_window_now,
    output logic                          o_send_allowed,
    output logic [swt_pkg::CHUNK_W-1:0]   o_chunk_size,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic [swt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [swt_pkg::WIN_W-1:0]     i_cfg_data
);
    import swt_pkg::*;

    logic [WIN_W-1:0] r_initial_window;
    logic [WIN_W-1:0] r_max_window;
    // 0.8 of a 32768-byte buffer, as a whole-byte limit
    logic [WIN_W-1:0] r_congest_bytes;

    logic  w_head_valid;
    t_work w_head;
    logic  w_head_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_window <= WIN_W'(65536);
            r_max_window     <= WIN_W'(1048576);
            r_congest_bytes  <= WIN_W'(26214);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INITIAL_WINDOW: r_initial_window <= i_cfg_data;
                CFG_MAX_WINDOW:     r_max_window     <= i_cfg_data;
                CFG_CONGEST_BYTES:  r_congest_bytes  <= i_cfg_data;
                default: ; // unmapped index: write dropped
            endcase
        end
    end

    // front: classification (congestion, set over limit) and request queue
    swt_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_req_type       (i_req_type),
        .i_stream_key     (i_stream_key),
        .i_window_value   (i_window_value),
        .i_send_bytes     (i_send_bytes),
        .i_buffer_tracked (i_buffer_tracked),
        .i_buffer_used    (i_buffer_used),
        .i_max_window     (r_max_window),
        .i_congest_bytes  (r_congest_bytes),
        .o_head_valid     (w_head_valid),
        .o_head           (w_head),
        .i_head_pop       (w_head_pop)
    );

    // back: table, window update, result queue
    swt_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head_valid     (w_head_valid),
        .i_head           (w_head),
        .o_head_pop       (w_head_pop),
        .i_initial_window (r_initial_window),
        .i_max_window     (r_max_window),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_window_now     (o_window_now),
        .o_send_allowed   (o_send_allowed),
        .o_chunk_size     (o_chunk_size)
    );

endmodule

// ===== hdl/swt_checker.sv =====
// Port-level checks of the stream window table, bound to the top level.
module swt_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          full,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [1:0]                    o_status,
    input  logic [swt_pkg::WIN_W-1:0]     o_window_now,
    input  logic [swt_pkg::CHUNK_W-1:0]   o_chunk_size
);
    import swt_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not cleared by reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_window_now) && $stable(o_status)))
        else $error("waiting result changed or vanished");

    a_chunk_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_chunk_size <= CHUNK_CAP))
        else $error("chunk size above cap");

    a_chunk_quarter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_window_now[WIN_W-1:2] < (WIN_W-2)'(CHUNK_CAP)))
        |-> (o_chunk_size == o_window_now[CHUNK_W+1:2]))
        else $error("chunk size is not a quarter of the window");

endmodule

bind stream_window_table_core swt_checker u_swt_checker (.*);

// ===== tb/sv/swt_window_check.sv =====
// Checker for the stream window table: tracks the table, predicts each result and compares.
module swt_window_check
    import swt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  logic [1:0]           i_req_type,
    input  logic [KEY_W-1:0]     i_stream_key,
    input  logic [WIN_W-1:0]     i_window_value,
    input  logic [WIN_W-1:0]     i_send_bytes,
    input  logic                 i_buffer_tracked,
    input  logic [WIN_W-1:0]     i_buffer_used,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  logic [1:0]           i_status,
    input  logic [WIN_W-1:0]     i_window_now,
    input  logic                 i_send_allowed,
    input  logic [CHUNK_W-1:0]   i_chunk_size,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WIN_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [WIN_W-1:0] init_win;
    logic [WIN_W-1:0] max_win;
    logic [WIN_W-1:0] congest_lim;
    logic [KEY_W-1:0] key_tab [STREAMS];
    logic [WIN_W-1:0] win_tab [STREAMS];
    bit               vld_tab [STREAMS];
    t_result          window_due [$];
    int               fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fails++;
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    function automatic int find_stream(input logic [KEY_W-1:0] key);
        for (int i = 0; i < STREAMS; i++) begin
            if (vld_tab[i] && key_tab[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // lowest free slot takes the stream; slots are never released
    function automatic int claim_slot(input logic [KEY_W-1:0] key, input logic [WIN_W-1:0] win);
        for (int i = 0; i < STREAMS; i++) begin
            if (!vld_tab[i]) begin
                vld_tab[i] = 1'b1;
                key_tab[i] = key;
                win_tab[i] = win;
                return i;
            end
        end
        return -1;
    endfunction

    function automatic t_result apply_request(input logic [1:0] req, input logic [KEY_W-1:0] key,
                                              input logic [WIN_W-1:0] wval,
                                              input logic [WIN_W-1:0] dsize, input logic trk,
                                              input logic [WIN_W-1:0] used);
        int               idx;
        logic [WIN_W:0]   dbl;
        logic [WIN_W-1:0] half;
        logic [WIN_W-1:0] flr;
        logic [WIN_W-1:0] win;
        logic [WIN_W-1:0] quarter;
        t_result          r;
        r.status = ST_OK;
        idx = find_stream(key);
        if (req == REQ_ADAPT) begin
            if (idx < 0) begin
                idx = claim_slot(key, init_win);
            end
            if (idx < 0) begin
                r.status = ST_FULL;
            end else if (trk && used > congest_lim) begin
                half = win_tab[idx] >> 1;
                flr  = init_win >> 2;
                win_tab[idx] = (half > flr) ? half : flr;
            end else begin
                dbl = {1'b0, win_tab[idx]} << 1;
                win_tab[idx] = (dbl < {1'b0, max_win}) ? dbl[WIN_W-1:0] : max_win;
            end
        end else if (req == REQ_SET) begin
            if (wval > max_win) begin
                r.status = ST_REJECT;
            end else begin
                if (idx < 0) begin
                    idx = claim_slot(key, wval);
                end
                if (idx < 0) begin
                    r.status = ST_FULL;
                end else begin
                    win_tab[idx] = wval;
                end
            end
        end
        // query and the unused code leave the table alone
        win      = (idx >= 0) ? win_tab[idx] : init_win;
        quarter  = win >> 2;
        r.window = win;
        r.send   = (dsize <= win);
        r.chunk  = (quarter > CHUNK_CAP) ? CHUNK_CAP : quarter[CHUNK_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            init_win    = 32'd65536;
            max_win     = 32'd1048576;
            congest_lim = 32'd26214;
            for (int i = 0; i < STREAMS; i++) begin
                vld_tab[i] = 1'b0;
            end
            window_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (window_due.size() == 0) begin
                    report_mismatch("unexpected result window", 64'(i_window_now), 64'd0);
                end else begin
                    want = window_due.pop_front();
                    if (i_status != want.status) begin
                        report_mismatch("status", 64'(i_status), 64'(want.status));
                    end
                    if (i_window_now != want.window) begin
                        report_mismatch("window_now", 64'(i_window_now), 64'(want.window));
                    end
                    if (i_send_allowed != want.send) begin
                        report_mismatch("send_allowed", 64'(i_send_allowed), 64'(want.send));
                    end
                    if (i_chunk_size != want.chunk) begin
                        report_mismatch("chunk_size", 64'(i_chunk_size), 64'(want.chunk));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INITIAL_WINDOW: init_win    = i_cfg_data;
                    CFG_MAX_WINDOW:     max_win     = i_cfg_data;
                    CFG_CONGEST_BYTES:  congest_lim = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                want = apply_request(i_req_type, i_stream_key, i_window_value,
                                     i_send_bytes, i_buffer_tracked, i_buffer_used);
                window_due = {window_due, want};
            end
        end
        o_pending    <= window_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/sv/stream_window_table_core_tb.sv =====
// Testbench top for the stream window table: stimulus, idling, config phases and verdict.
module stream_window_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import swt_pkg::*;

    // request code the block treats as a query
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int POOL_N          = 12;   // stream ids that most items reuse
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 230;
    localparam int HOLD_CYCLES     = 300;  // long receiver hold-off to fill the block

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 push             = 1'b0;
    logic                 full;
    logic [1:0]           i_req_type       = '0;
    logic [KEY_W-1:0]     i_stream_key     = '0;
    logic [WIN_W-1:0]     i_window_value   = '0;
    logic [WIN_W-1:0]     i_send_bytes     = '0;
    logic                 i_buffer_tracked = 1'b0;
    logic [WIN_W-1:0]     i_buffer_used    = '0;
    logic                 empty;
    logic                 pop              = 1'b0;
    logic [1:0]           o_status;
    logic [WIN_W-1:0]     o_window_now;
    logic                 o_send_allowed;
    logic [CHUNK_W-1:0]   o_chunk_size;
    logic                 i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx        = '0;
    logic [WIN_W-1:0]     i_cfg_data       = '0;

    int fail_count;
    int pend;

    // idling percentages per cycle, changed per phase
    int snd_idle  = 0;
    int rcv_stall = 0;
    bit hold_go   = 1'b0;

    // register values last written, used only to steer the random fields
    logic [WIN_W-1:0] cfg_init = 32'd65536;
    logic [WIN_W-1:0] cfg_max  = 32'd1048576;
    logic [WIN_W-1:0] cfg_cong = 32'd26214;

    logic [KEY_W-1:0] id_pool [POOL_N];

    always #2 i_clk = ~i_clk;

    stream_window_table_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_req_type      (i_req_type),
        .i_stream_key    (i_stream_key),
        .i_window_value  (i_window_value),
        .i_send_bytes    (i_send_bytes),
        .i_buffer_tracked(i_buffer_tracked),
        .i_buffer_used   (i_buffer_used),
        .empty           (empty),
        .pop             (pop),
        .o_status        (o_status),
        .o_window_now    (o_window_now),
        .o_send_allowed  (o_send_allowed),
        .o_chunk_size    (o_chunk_size),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    swt_window_check u_window_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_req_type      (i_req_type),
        .i_stream_key    (i_stream_key),
        .i_window_value  (i_window_value),
        .i_send_bytes    (i_send_bytes),
        .i_buffer_tracked(i_buffer_tracked),
        .i_buffer_used   (i_buffer_used),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_status        (o_status),
        .i_window_now    (o_window_now),
        .i_send_allowed  (o_send_allowed),
        .i_chunk_size    (o_chunk_size),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pend)
    );

    // Offer one item and return at the edge that accepts it. push stays high;
    // the caller lowers it only if a gap follows.
    task automatic offer_item(input logic [1:0] req, input logic [KEY_W-1:0] id,
                              input logic [WIN_W-1:0] wv, input logic [WIN_W-1:0] ds,
                              input logic tk, input logic [WIN_W-1:0] bu);
        push             <= 1'b1;
        i_req_type       <= req;
        i_stream_key     <= id;
        i_window_value   <= wv;
        i_send_bytes     <= ds;
        i_buffer_tracked <= tk;
        i_buffer_used    <= bu;
        do @(posedge i_clk); while (full);
    endtask

    // Offer, then maybe idle a random number of cycles.
    task automatic send_item(input logic [1:0] req, input logic [KEY_W-1:0] id,
                             input logic [WIN_W-1:0] wv, input logic [WIN_W-1:0] ds,
                             input logic tk, input logic [WIN_W-1:0] bu);
        offer_item(req, id, wv, ds, tk, bu);
        if ($urandom_range(0, 99) < snd_idle) begin
            push <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < snd_idle);
        end
    endtask

    // Lower push and wait until every accepted item has its result back.
    // The first edge lets the pending count catch up with the last push.
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (pend != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Three back-to-back register writes, one per edge.
    task automatic write_window_config(input logic [WIN_W-1:0] init_w,
                                       input logic [WIN_W-1:0] max_w,
                                       input logic [WIN_W-1:0] cong);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_INITIAL_WINDOW;
        i_cfg_data <= init_w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_WINDOW;
        i_cfg_data <= max_w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_CONGEST_BYTES;
        i_cfg_data <= cong;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cfg_init = init_w;
        cfg_max  = max_w;
        cfg_cong = cong;
    endtask

    // Random item: mostly streams from the pool so windows get adapted many
    // times over; now and then a fresh id, which fills the table and later
    // runs into the table-full path.
    task automatic send_random_item();
        logic [1:0]       req;
        logic [KEY_W-1:0] id;
        logic [WIN_W-1:0] wv;
        logic [WIN_W-1:0] ds;
        logic [WIN_W-1:0] bu;
        int               roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)      req = REQ_ADAPT;
        else if (roll < 70) req = REQ_SET;
        else if (roll < 93) req = REQ_QUERY;
        else                req = REQ_UNUSED;
        if ($urandom_range(0, 99) < 5) id = {$urandom, $urandom};
        else                           id = id_pool[$urandom_range(0, POOL_N - 1)];
        case ($urandom_range(0, 5))
            0:       wv = $urandom;
            1:       wv = cfg_max;          // exactly at the limit
            2:       wv = cfg_max + 1;      // just above it
            3:       wv = $urandom_range(0, cfg_max);
            4:       wv = '0;
            default: wv = $urandom_range(0, 8000);
        endcase
        case ($urandom_range(0, 4))
            0:       ds = $urandom;
            1:       ds = $urandom_range(0, 32'h0020_0000);
            2:       ds = '0;
            3:       ds = '1;
            default: ds = $urandom_range(0, 20000);
        endcase
        case ($urandom_range(0, 3))
            0:       bu = $urandom;
            1:       bu = cfg_cong;         // at the threshold: not congested
            2:       bu = cfg_cong + 1;     // one above: congested
            default: bu = $urandom_range(0, 60000);
        endcase
        send_item(req, id, wv, ds, 1'($urandom), bu);
    endtask

    // Config per phase: defaults, both extremes, small initial window with low limit, window above the max, random.
    task automatic setup_phase(input int ph);
        case (ph)
            0: write_window_config(32'd65536, 32'd1048576, 32'd26214);
            1: write_window_config('1, '1, '1);
            2: write_window_config('0, '0, '0);
            3: write_window_config(32'd4096, 32'd1048576, 32'd1000);
            4: write_window_config($urandom_range(0, 200000), $urandom_range(0, 4000000),
                                   $urandom_range(0, 60000));
            5: write_window_config(32'd1048576, 32'd5000, 32'd26214);
            6: write_window_config('1, 32'h8000_0000, '0);
            default: write_window_config($urandom, $urandom, $urandom);
        endcase
        // idling modes: none, sender idle, receiver stalled, both
        case (ph % 4)
            0: begin snd_idle = 0;  rcv_stall = 0;  end
            1: begin snd_idle = 85; rcv_stall = 0;  end
            2: begin snd_idle = 0;  rcv_stall = 85; end
            default: begin snd_idle = 24; rcv_stall = 24; end
        endcase
    endtask

    // Directed items at reset config: initial 65536, max 1 MiB, limit 26214.
    task automatic run_directed();
        logic [KEY_W-1:0] k0;
        logic [KEY_W-1:0] k1;
        logic [KEY_W-1:0] k2;
        k0 = '0;
        k1 = '1;
        k2 = 64'h1;
        // unknown stream: initial window, fit check right at the edge
        send_item(REQ_QUERY, k0, '0, '0, 1'b0, '0);
        send_item(REQ_QUERY, k0, '0, 32'd65536, 1'b0, '0);
        send_item(REQ_QUERY, k0, '0, 32'd65537, 1'b0, '0);
        // new stream, untracked buffer counts as not congested even when huge
        send_item(REQ_ADAPT, k0, '0, '1, 1'b0, '1);
        // threshold itself is not congestion, one above is
        send_item(REQ_ADAPT, k0, '0, '0, 1'b1, 32'd26214);
        send_item(REQ_ADAPT, k0, '0, '0, 1'b1, 32'd26215);
        // keep doubling until the cap holds
        repeat (4) send_item(REQ_ADAPT, k0, '0, 32'd1048576, 1'b0, '0);
        // halving down to the floor of a quarter of the initial window
        repeat (3) send_item(REQ_ADAPT, k1, '1, '0, 1'b1, '1);
        // set at the max is taken, one above is refused
        send_item(REQ_SET, k1, 32'd1048576, '0, 1'b0, '0);
        send_item(REQ_SET, k1, 32'd1048577, '0, 1'b0, '0);
        // refused set on an unknown stream reports the initial window
        send_item(REQ_SET, 64'hA5A5_5A5A_C3C3_3C3C, '1, '0, 1'b1, '0);
        // zero window, then chunk just under, at and above the 1400 cap
        send_item(REQ_SET, k2, '0, '0, 1'b0, '0);
        send_item(REQ_SET, k2, 32'd5599, 32'd5599, 1'b0, '0);
        send_item(REQ_SET, k2, 32'd5600, 32'd5601, 1'b0, '0);
        send_item(REQ_SET, k2, 32'd5604, '0, 1'b0, '0);
        // unused request code acts as a query
        send_item(REQ_UNUSED, k2, '0, '1, 1'b1, '1);
        send_item(REQ_ADAPT, k2, '0, '0, 1'b1, '0);
    endtask

    // Receiver: random stalls, plus one long hold-off when asked, counted here.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                pop <= ($urandom_range(0, 99) >= rcv_stall);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < POOL_N; i++) begin
            id_pool[i] = {$urandom, $urandom};
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            setup_phase(ph);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // with no idling the sender keeps offering through the
                // hold-off, so both queues fill and full must rise
                if (ph % 4 == 0 && n == 40) begin
                    hold_go = 1'b1;
                end
                send_random_item();
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pend == 0) begin
            $display("stream_window_table_core_tb: PASS");
        end else begin
            $display("stream_window_table_core_tb: FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("stream_window_table_core_tb: FAIL");
        $finish;
    end

endmodule
